[sv/tgrm_pkg.sv]
// Shared types, constants and unit request/response structs for the tremolo gain ramp mixer.
// No dependencies; imported by every module of the block.
package tgrm_pkg;

    localparam int unsigned FRAMES_PER_PERIOD_DEF = 64;

    localparam int unsigned REG_IDX_W = 1;
    localparam int unsigned CFG_W     = 23;
    localparam logic [REG_IDX_W-1:0] REG_RATE  = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEPTH = 1'd1;

    localparam logic REQ_PERIOD = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [1:0] CMD_KEEP = 2'd0;
    localparam logic [1:0] CMD_RUN  = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_STOP = 2'd2
    } mode_t;

    localparam logic signed [23:0] OSC_ONE    = 24'sd4194304;
    localparam logic [23:0]        SIN_STOP   = 24'd209715;
    localparam logic [23:0]        GAIN_RESET = 24'd838861;
    localparam logic [23:0]        GAIN_MAX   = 24'd16777215;

    // serial multiplier: signed a times unsigned b, one 4-bit digit of b a cycle
    localparam int unsigned MUL_AW    = 31;
    localparam int unsigned MUL_BW    = 28;
    localparam int unsigned MUL_DW    = 4;
    localparam int unsigned MUL_PW    = 60;
    localparam int unsigned MUL_STEPS = MUL_BW / MUL_DW;
    localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);

    localparam logic [MUL_BW-1:0] K_HI = 28'd4404019;
    localparam logic [MUL_BW-1:0] K_LO = 28'd3984589;

    localparam logic signed [MUL_PW-1:0] RND_HALF22 = 60'sh200000;
    localparam logic signed [MUL_PW-1:0] RND_HALF23 = 60'sh400000;

    // restoring divider, one quotient bit a cycle
    localparam int unsigned DIV_RW        = 30;
    localparam int unsigned DIV_DW        = 29;
    localparam int unsigned DIV_NW        = 25;
    localparam int unsigned DIV_CW        = 5;
    localparam int unsigned DIV_OSC_ITERS = 23;

    // square root, one root bit a cycle
    localparam int unsigned SQ_IW    = 56;
    localparam int unsigned SQ_OW    = 28;
    localparam int unsigned SQ_RW    = 31;
    localparam int unsigned SQ_CNT_W = $clog2(SQ_OW);

    typedef struct packed {
        logic                     start;
        logic signed [MUL_AW-1:0] a;
        logic [MUL_BW-1:0]        b;
    } mul_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [MUL_PW-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic [DIV_RW-1:0] rem_init;
        logic [DIV_NW-1:0] num;
        logic [DIV_CW-1:0] iters;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic             start;
        logic [SQ_IW-1:0] radicand;
    } sq_req_t;

    typedef struct packed {
        logic             done;
        logic [SQ_OW-1:0] root;
    } sq_rsp_t;

endpackage

[sv/tgrm_mul.sv]
// Digit-serial multiplier: signed operand times unsigned operand, 4 bits a cycle.
// Depends on tgrm_pkg.
module tgrm_mul import tgrm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic                       busy_reg;
    logic                       done_reg;
    logic [MUL_CNT_W-1:0]       cnt_reg;
    logic signed [MUL_AW-1:0]   a_reg;
    logic [MUL_BW-1:0]          b_reg;
    logic signed [MUL_PW-1:0]   acc_reg;
    logic [MUL_DW-1:0]          digit;
    logic signed [MUL_AW+MUL_DW:0] term;
    logic signed [MUL_PW-1:0]   acc_next;

    always_comb
    begin
        digit    = b_reg[MUL_BW-1 -: MUL_DW];
        term     = a_reg * $signed({1'b0, digit});
        acc_next = (acc_reg <<< MUL_DW) + MUL_PW'(term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                a_reg    <= req.a;
                b_reg    <= req.b;
                acc_reg  <= '0;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                b_reg   <= b_reg << MUL_DW;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

[sv/tgrm_sqrt.sv]
// Bit-serial integer square root (floor), one root bit a cycle.
// Depends on tgrm_pkg.
module tgrm_sqrt import tgrm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  sq_req_t req,
    output sq_rsp_t rsp
);

    logic                busy_reg;
    logic                done_reg;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic [SQ_IW-1:0]    rad_reg;
    logic [SQ_RW-1:0]    rem_reg;
    logic [SQ_OW-1:0]    root_reg;
    logic [SQ_RW-1:0]    rem2;
    logic [SQ_RW-1:0]    trial;
    logic                take;

    always_comb
    begin
        rem2  = {rem_reg[SQ_RW-3:0], rad_reg[SQ_IW-1 -: 2]};
        trial = SQ_RW'({root_reg, 2'b01});
        take  = (rem2 >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rad_reg  <= req.radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            else if (busy_reg)
            begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= take ? (rem2 - trial) : rem2;
                root_reg <= {root_reg[SQ_OW-2:0], take};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == SQ_CNT_W'(SQ_OW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

[sv/tgrm_div.sv]
// Restoring divider, one quotient bit a cycle, with a preset partial remainder.
// Depends on tgrm_pkg.
module tgrm_div import tgrm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_CW-1:0] iters_reg;
    logic [DIV_RW-1:0] rem_reg;
    logic [DIV_NW-1:0] num_reg;
    logic [DIV_NW-1:0] quot_reg;
    logic [DIV_DW-1:0] div_reg;
    logic [DIV_RW-1:0] rem2;
    logic [DIV_RW-1:0] dvs;
    logic              take;

    always_comb
    begin
        rem2 = {rem_reg[DIV_RW-2:0], num_reg[DIV_NW-1]};
        dvs  = DIV_RW'(div_reg);
        take = (rem2 >= dvs);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            iters_reg <= '0;
            rem_reg   <= '0;
            num_reg   <= '0;
            quot_reg  <= '0;
            div_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                cnt_reg   <= '0;
                iters_reg <= req.iters;
                rem_reg   <= req.rem_init;
                num_reg   <= req.num;
                quot_reg  <= '0;
                div_reg   <= req.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg  <= take ? (rem2 - dvs) : rem2;
                num_reg  <= num_reg << 1;
                quot_reg <= {quot_reg[DIV_NW-2:0], take};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == iters_reg - 1'b1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

[sv/tremolo_gain_ramp_mixer_unit.sv]
// Four-channel swell/tremolo gain stage with per-sample gain ramp and saturating bus mix.
// Depends on tgrm_pkg, tgrm_mul, tgrm_sqrt and tgrm_div.
//
// One item is worked on at a time; in_ready is high only while the sequencer is idle, and a
// finished mix item waits in the output register while the next item is taken. All products,
// roots and quotients come from one 4-bit-digit serial multiplier, a bit-serial square root and
// a bit-serial divider. A sample item takes four products. A period-start item takes two clamp
// products and the ramp division with the tremolo off, and with it running the oscillator
// advance, length, two renormalizing divisions (skipped for a zero length) and two modulation
// products on top.
module tremolo_gain_ramp_mixer_unit import tgrm_pkg::*;
#(
    parameter int unsigned FRAMES_PER_PERIOD = FRAMES_PER_PERIOD_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [23:0]          swell,
    input  logic [1:0]           trem_cmd,
    input  logic signed [23:0]   dry_ch0,
    input  logic signed [23:0]   dry_ch1,
    input  logic signed [23:0]   dry_ch2,
    input  logic signed [23:0]   dry_ch3,
    input  logic signed [31:0]   bus_ch0,
    input  logic signed [31:0]   bus_ch1,
    input  logic signed [31:0]   bus_ch2,
    input  logic signed [31:0]   bus_ch3,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   mix_ch0,
    output logic signed [31:0]   mix_ch1,
    output logic signed [31:0]   mix_ch2,
    output logic signed [31:0]   mix_ch3
);

    localparam int unsigned G_W = 30;
    localparam int unsigned W_W = 28;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_OSC_MC,
        ST_OSC_MS,
        ST_OSC_SQC,
        ST_OSC_SQS,
        ST_OSC_SQRT,
        ST_OSC_DC,
        ST_OSC_DS,
        ST_OSC_STOP,
        ST_MOD_D,
        ST_MOD_S,
        ST_CLAMP_HI,
        ST_CLAMP_LO,
        ST_STEP_DIV,
        ST_SMP_MUL,
        ST_SMP_OUT
    } state_t;

    function automatic logic [W_W-1:0] abs_w(input logic signed [W_W-1:0] v);
        return v[W_W-1] ? W_W'(-v) : W_W'(v);
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        logic signed [25:0] lo;
        logic signed [25:0] hi;
        lo = -26'sd8388608;
        hi = 26'sd8388607;
        priority if (v < lo)
            return 24'sh800000;
        else if (v > hi)
            return 24'sh7FFFFF;
        else
            return 24'(v);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [33:0] lo;
        logic signed [33:0] hi;
        lo = -34'sd2147483648;
        hi = 34'sd2147483647;
        priority if (v < lo)
            return 32'sh80000000;
        else if (v > hi)
            return 32'sh7FFFFFFF;
        else
            return 32'(v);
    endfunction

    state_t                   state_reg;
    logic                     run_reg;
    mode_t                    mode_reg;
    logic [CFG_W-1:0]         rate_reg;
    logic [CFG_W-1:0]         depth_reg;
    logic signed [23:0]       cos_reg;
    logic signed [23:0]       sin_reg;
    logic [23:0]              gain_reg;
    logic signed [23:0]       step_reg;
    logic [23:0]              swell_reg;
    logic signed [W_W-1:0]    s1_reg;
    logic signed [W_W-1:0]    c1_reg;
    logic [SQ_IW-1:0]         r2_reg;
    logic [SQ_OW-1:0]         t_reg;
    logic signed [25:0]       fac_reg;
    logic signed [G_W-1:0]    g_reg;
    logic signed [G_W-1:0]    diff_reg;
    logic [1:0]               ch_reg;
    logic signed [23:0]       dry_reg [4];
    logic signed [31:0]       bus_reg [4];
    logic signed [31:0]       sum_reg [4];
    logic signed [31:0]       mix_reg [4];
    logic                     out_valid_reg;

    mul_req_t                 mul_req;
    mul_rsp_t                 mul_rsp;
    sq_req_t                  sq_req;
    sq_rsp_t                  sq_rsp;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    logic                     accept;
    mode_t                    mode_next;
    logic                     mul_state;
    logic                     div_state;
    logic signed [MUL_PW-1:0] rnd22;
    logic signed [MUL_PW-1:0] rnd23;
    logic [W_W-1:0]           c1_abs;
    logic [W_W-1:0]           s1_abs;
    logic [23:0]              sin_abs;
    logic signed [G_W-1:0]    bound;
    logic signed [G_W-1:0]    g_lo;
    logic signed [G_W-1:0]    g_lim;
    logic [DIV_NW-1:0]        diff_abs;
    logic signed [23:0]       quot_s;
    logic signed [25:0]       step_q;
    logic signed [25:0]       gain_sum;
    logic [23:0]              gain_next;
    logic signed [31:0]       sum_next;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        mode_next = mode_reg;
        if (trem_cmd == CMD_RUN)
            mode_next = MODE_RUN;
        else if (trem_cmd == CMD_STOP && mode_reg != MODE_OFF)
            mode_next = MODE_STOP;
    end

    always_comb
    begin
        rnd22    = (mul_rsp.prod + RND_HALF22) >>> 22;
        rnd23    = (mul_rsp.prod + RND_HALF23) >>> 23;
        c1_abs   = abs_w(c1_reg);
        s1_abs   = abs_w(s1_reg);
        sin_abs  = sin_reg[23] ? 24'(-sin_reg) : 24'(sin_reg);
        bound    = G_W'(rnd22);
        g_lo     = (g_reg < bound) ? bound : g_reg;
        if (g_lo < 0)
            g_lim = '0;
        else if (g_lo > G_W'($signed({1'b0, GAIN_MAX})))
            g_lim = G_W'($signed({1'b0, GAIN_MAX}));
        else
            g_lim = g_lo;
        diff_abs = diff_reg[G_W-1] ? DIV_NW'(-diff_reg) : DIV_NW'(diff_reg);
        quot_s   = 24'(div_rsp.quot);
        step_q   = diff_reg[G_W-1] ? -$signed({1'b0, div_rsp.quot})
                                   : $signed({1'b0, div_rsp.quot});
        gain_sum = $signed({2'b00, gain_reg}) + 26'(step_reg);
        if (gain_sum < 0)
            gain_next = '0;
        else if (gain_sum > $signed({2'b00, GAIN_MAX}))
            gain_next = GAIN_MAX;
        else
            gain_next = 24'(gain_sum);
        sum_next = sat32(34'(bus_reg[ch_reg]) + 34'(rnd23));
    end

    always_comb
    begin
        mul_state = 1'b1;
        mul_req.a = '0;
        mul_req.b = '0;
        unique case (state_reg)
            ST_OSC_MC:
            begin
                mul_req.a = MUL_AW'(cos_reg);
                mul_req.b = MUL_BW'(rate_reg);
            end
            ST_OSC_MS:
            begin
                mul_req.a = MUL_AW'(s1_reg);
                mul_req.b = MUL_BW'(rate_reg);
            end
            ST_OSC_SQC:
            begin
                mul_req.a = MUL_AW'($signed({1'b0, c1_abs}));
                mul_req.b = c1_abs;
            end
            ST_OSC_SQS:
            begin
                mul_req.a = MUL_AW'($signed({1'b0, s1_abs}));
                mul_req.b = s1_abs;
            end
            ST_MOD_D:
            begin
                mul_req.a = MUL_AW'(sin_reg);
                mul_req.b = MUL_BW'(depth_reg);
            end
            ST_MOD_S:
            begin
                mul_req.a = MUL_AW'(fac_reg);
                mul_req.b = MUL_BW'(swell_reg);
            end
            ST_CLAMP_HI:
            begin
                mul_req.a = MUL_AW'($signed({1'b0, gain_reg}));
                mul_req.b = K_HI;
            end
            ST_CLAMP_LO:
            begin
                mul_req.a = MUL_AW'($signed({1'b0, gain_reg}));
                mul_req.b = K_LO;
            end
            ST_SMP_MUL:
            begin
                mul_req.a = MUL_AW'(dry_reg[ch_reg]);
                mul_req.b = MUL_BW'(gain_reg);
            end
            default:
                mul_state = 1'b0;
        endcase
        mul_req.start = mul_state && !run_reg;
    end

    always_comb
    begin
        div_state        = 1'b1;
        div_req.rem_init = '0;
        div_req.num      = '0;
        div_req.iters    = DIV_CW'(DIV_NW);
        div_req.divisor  = DIV_DW'(FRAMES_PER_PERIOD);
        unique case (state_reg)
            ST_OSC_DC:
            begin
                div_req.rem_init = DIV_RW'(c1_abs >> 1);
                div_req.num      = {c1_abs[0], {(DIV_NW-1){1'b0}}};
                div_req.iters    = DIV_CW'(DIV_OSC_ITERS);
                div_req.divisor  = DIV_DW'(t_reg);
            end
            ST_OSC_DS:
            begin
                div_req.rem_init = DIV_RW'(s1_abs >> 1);
                div_req.num      = {s1_abs[0], {(DIV_NW-1){1'b0}}};
                div_req.iters    = DIV_CW'(DIV_OSC_ITERS);
                div_req.divisor  = DIV_DW'(t_reg);
            end
            ST_STEP_DIV:
            begin
                div_req.num = diff_abs;
            end
            default:
                div_state = 1'b0;
        endcase
        div_req.start   = div_state && !run_reg;
        sq_req.start    = (state_reg == ST_OSC_SQRT) && !run_reg;
        sq_req.radicand = r2_reg;
    end

    tgrm_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    tgrm_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

    tgrm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_reg       <= 1'b0;
            mode_reg      <= MODE_OFF;
            rate_reg      <= '0;
            depth_reg     <= '0;
            cos_reg       <= OSC_ONE;
            sin_reg       <= '0;
            gain_reg      <= GAIN_RESET;
            step_reg      <= '0;
            swell_reg     <= '0;
            s1_reg        <= '0;
            c1_reg        <= '0;
            r2_reg        <= '0;
            t_reg         <= '0;
            fac_reg       <= '0;
            g_reg         <= '0;
            diff_reg      <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                dry_reg[i] <= '0;
                bus_reg[i] <= '0;
                sum_reg[i] <= '0;
                mix_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RATE:  rate_reg  <= cfg_data;
                    REG_DEPTH: depth_reg <= cfg_data;
                endcase
            end

            if (state_reg == ST_SMP_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (mul_req.start || div_req.start || sq_req.start)
                run_reg <= 1'b1;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (req_type == REQ_PERIOD)
                        begin
                            mode_reg  <= mode_next;
                            swell_reg <= swell;
                            g_reg     <= G_W'($signed({1'b0, swell}));
                            state_reg <= (mode_next != MODE_OFF) ? ST_OSC_MC : ST_CLAMP_HI;
                        end
                        else
                        begin
                            gain_reg   <= gain_next;
                            dry_reg[0] <= dry_ch0;
                            dry_reg[1] <= dry_ch1;
                            dry_reg[2] <= dry_ch2;
                            dry_reg[3] <= dry_ch3;
                            bus_reg[0] <= bus_ch0;
                            bus_reg[1] <= bus_ch1;
                            bus_reg[2] <= bus_ch2;
                            bus_reg[3] <= bus_ch3;
                            ch_reg     <= '0;
                            state_reg  <= ST_SMP_MUL;
                        end
                    end
                end
                ST_OSC_MC:
                begin
                    if (mul_rsp.done)
                    begin
                        run_reg   <= 1'b0;
                        s1_reg    <= W_W'(rnd22) + W_W'(sin_reg);
                        state_reg <= ST_OSC_MS;
                    end
                end
                ST_OSC_MS:
                begin
                    if (mul_rsp.done)
                    begin
                        run_reg   <= 1'b0;
                        c1_reg    <= W_W'(cos_reg) - W_W'(rnd22);
                        state_reg <= ST_OSC_SQC;
                    end
                end
                ST_OSC_SQC:
                begin
                    if (mul_rsp.done)
                    begin
                        run_reg   <= 1'b0;
                        r2_reg    <= SQ_IW'(mul_rsp.prod);
                        state_reg <= ST_OSC_SQS;
                    end
                end
                ST_OSC_SQS:
                begin
                    if (mul_rsp.done)
                    begin
                        run_reg   <= 1'b0;
                        r2_reg    <= r2_reg + SQ_IW'(mul_rsp.prod);
                        state_reg <= ST_OSC_SQRT;
                    end
                end
                ST_OSC_SQRT:
                begin
                    if (sq_rsp.done)
                    begin
                        run_reg <= 1'b0;
                        t_reg   <= sq_rsp.root;
                        if (sq_rsp.root == '0)
                        begin
                            cos_reg   <= OSC_ONE;
                            sin_reg   <= '0;
                            state_reg <= ST_OSC_STOP;
                        end
                        else
                            state_reg <= ST_OSC_DC;
                    end
                end
                ST_OSC_DC:
                begin
                    if (div_rsp.done)
                    begin
                        run_reg   <= 1'b0;
                        cos_reg   <= c1_reg[W_W-1] ? -quot_s : quot_s;
                        state_reg <= ST_OSC_DS;
                    end
                end
                ST_OSC_DS:
                begin
                    if (div_rsp.done)
                    begin
                        run_reg   <= 1'b0;
                        sin_reg   <= s1_reg[W_W-1] ? -quot_s : quot_s;
                        state_reg <= ST_OSC_STOP;
                    end
                end
                ST_OSC_STOP:
                begin
                    if (mode_reg == MODE_STOP && sin_abs <= SIN_STOP)
                    begin
                        mode_reg <= MODE_OFF;
                        cos_reg  <= OSC_ONE;
                        sin_reg  <= '0;
                    end
                    state_reg <= ST_MOD_D;
                end
                ST_MOD_D:
                begin
                    if (mul_rsp.done)
                    begin
                        run_reg   <= 1'b0;
                        fac_reg   <= 26'(OSC_ONE) + 26'(rnd22);
                        state_reg <= ST_MOD_S;
                    end
                end
                ST_MOD_S:
                begin
                    if (mul_rsp.done)
                    begin
                        run_reg   <= 1'b0;
                        g_reg     <= G_W'(rnd22);
                        state_reg <= ST_CLAMP_HI;
                    end
                end
                ST_CLAMP_HI:
                begin
                    if (mul_rsp.done)
                    begin
                        run_reg <= 1'b0;
                        if (g_reg > bound)
                            g_reg <= bound;
                        state_reg <= ST_CLAMP_LO;
                    end
                end
                ST_CLAMP_LO:
                begin
                    if (mul_rsp.done)
                    begin
                        run_reg   <= 1'b0;
                        diff_reg  <= g_lim - G_W'($signed({1'b0, gain_reg}));
                        state_reg <= ST_STEP_DIV;
                    end
                end
                ST_STEP_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        run_reg   <= 1'b0;
                        step_reg  <= sat24(step_q);
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SMP_MUL:
                begin
                    if (mul_rsp.done)
                    begin
                        run_reg         <= 1'b0;
                        sum_reg[ch_reg] <= sum_next;
                        ch_reg          <= ch_reg + 1'b1;
                        if (ch_reg == 2'd3)
                            state_reg <= ST_SMP_OUT;
                    end
                end
                ST_SMP_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        for (int i = 0; i < 4; i++)
                            mix_reg[i] <= sum_reg[i];
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign mix_ch0   = mix_reg[0];
    assign mix_ch1   = mix_reg[1];
    assign mix_ch2   = mix_reg[2];
    assign mix_ch3   = mix_reg[3];

    a_idle_no_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !run_reg)
        else $error("arithmetic unit still running while idle");

    a_out_from_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_SMP_OUT))
        else $error("mix item presented outside the push state");

    a_stop_resets_osc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OSC_STOP && mode_reg == MODE_STOP && sin_abs <= SIN_STOP)
        |=> (mode_reg == MODE_OFF && sin_reg == '0 && cos_reg == OSC_ONE))
        else $error("tremolo stop did not reset the oscillator");

    a_done_while_run: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_rsp.done || div_rsp.done || sq_rsp.done) |-> run_reg)
        else $error("unit completion without a pending request");

endmodule

[verif/tb_tremolo_gain_ramp_mixer_unit.sv]
// Self-checking testbench for the tremolo gain ramp mixer: directed and random period/sample
// items against a bit-accurate gain and oscillator predictor. Depends on tgrm_pkg and the RTL.
module tb_tremolo_gain_ramp_mixer_unit;
    import tgrm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              kind;
        logic [23:0]       swell;
        logic [1:0]        cmd;
        logic signed [23:0] dry0, dry1, dry2, dry3;
        logic signed [31:0] bus0, bus1, bus2, bus3;
    } frame_t;

    typedef struct packed {
        logic signed [31:0] m0, m1, m2, m3;
    } mix_t;

    localparam longint K_HI_V = 4404019;
    localparam longint K_LO_V = 3984589;
    localparam longint ONE_V  = 4194304;

    logic clk, rst_n;
    logic cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid, in_ready, out_valid, out_ready;
    frame_t drv;
    logic signed [31:0] mix_ch0, mix_ch1, mix_ch2, mix_ch3;

    frame_t pending[$];
    mix_t   mix_expected[$];
    int     errors;
    int     accepted_items;
    bit     idle_en;
    bit     hold_off;

    logic [22:0] rate_r, depth_r;
    mode_t       mode_r;
    longint      cos_r, sin_r, gain_r, step_r;

    tremolo_gain_ramp_mixer_unit u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .req_type(drv.kind), .swell(drv.swell), .trem_cmd(drv.cmd),
        .dry_ch0(drv.dry0), .dry_ch1(drv.dry1), .dry_ch2(drv.dry2), .dry_ch3(drv.dry3),
        .bus_ch0(drv.bus0), .bus_ch1(drv.bus1), .bus_ch2(drv.bus2), .bus_ch3(drv.bus3),
        .out_valid(out_valid), .out_ready(out_ready),
        .mix_ch0(mix_ch0), .mix_ch1(mix_ch1), .mix_ch2(mix_ch2), .mix_ch3(mix_ch3)
    );

    function automatic longint rshr(longint v, int k);
        return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    task automatic step_oscillator();
        longint s1, c1, t;
        s1 = sin_r + rshr(longint'(rate_r) * cos_r, 22);
        c1 = cos_r - rshr(longint'(rate_r) * s1, 22);
        t  = int_sqrt(longint'(c1 * c1) + longint'(s1 * s1));
        if (t == 0) begin
            cos_r = ONE_V;
            sin_r = 0;
        end
        else begin
            cos_r = clip((c1 * ONE_V) / t, -8388608, 8388607);
            sin_r = clip((s1 * ONE_V) / t, -8388608, 8388607);
        end
    endtask

    task automatic predict_mix(input frame_t f);
        longint g, hi, lo, f_mod, d, s;
        mix_t m;
        logic signed [31:0] r[4];
        logic signed [23:0] dv[4];
        logic signed [31:0] bv[4];
        if (f.kind == REQ_PERIOD) begin
            g = longint'(f.swell);
            if (f.cmd == CMD_RUN) mode_r = MODE_RUN;
            else if (f.cmd == CMD_STOP && mode_r != MODE_OFF) mode_r = MODE_STOP;
            if (mode_r != MODE_OFF) begin
                step_oscillator();
                if (mode_r == MODE_STOP && sin_r <= 209715 && sin_r >= -209715) begin
                    mode_r = MODE_OFF;
                    cos_r = ONE_V;
                    sin_r = 0;
                end
                f_mod = ONE_V + rshr(longint'(depth_r) * sin_r, 22);
                g = rshr(g * f_mod, 22);
            end
            hi = rshr(gain_r * K_HI_V, 22);
            lo = rshr(gain_r * K_LO_V, 22);
            if (g > hi) g = hi;
            if (g < lo) g = lo;
            g = clip(g, 0, 16777215);
            step_r = clip((g - gain_r) / longint'(FRAMES_PER_PERIOD_DEF), -8388608, 8388607);
            return;
        end
        gain_r = clip(gain_r + step_r, 0, 16777215);
        dv = '{f.dry0, f.dry1, f.dry2, f.dry3};
        bv = '{f.bus0, f.bus1, f.bus2, f.bus3};
        for (int i = 0; i < 4; i++) begin
            d = longint'(dv[i]);
            s = longint'(bv[i]) + rshr(d * gain_r, 23);
            r[i] = 32'(clip(s, -64'sd2147483648, 64'sd2147483647));
        end
        m = '{r[0], r[1], r[2], r[3]};
        mix_expected.push_back(m);
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            drv <= '0;
        end
        else begin
            if (in_valid && in_ready) begin
                predict_mix(drv);
                accepted_items++;
            end
            if (!in_valid || in_ready) begin
                if (pending.size() > 0 && !hold_off
                    && !(idle_en && $urandom_range(99) < 10)) begin
                    drv <= pending.pop_front();
                    in_valid <= 1'b1;
                end
                else in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) out_ready <= 1'b0;
        else begin
            if (out_valid && out_ready) begin
                if (mix_expected.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected mix item %h %h %h %h",
                        mix_ch0, mix_ch1, mix_ch2, mix_ch3);
                end
                else begin
                    mix_t e;
                    e = mix_expected.pop_front();
                    if (e.m0 !== mix_ch0 || e.m1 !== mix_ch1 || e.m2 !== mix_ch2
                        || e.m3 !== mix_ch3) begin
                        errors++;
                        if (errors <= 10)
                            $display("mix mismatch exp %h %h %h %h got %h %h %h %h",
                                e.m0, e.m1, e.m2, e.m3, mix_ch0, mix_ch1, mix_ch2, mix_ch3);
                    end
                end
            end
            out_ready <= !(idle_en && $urandom_range(99) < 10);
        end
    end

    function automatic frame_t rand_frame(bit kind, bit wild);
        frame_t f;
        f.kind  = kind;
        f.swell = wild ? 24'($urandom) : 24'($urandom_range(8388608));
        f.cmd   = 2'($urandom_range(3));
        f.dry0 = 24'($urandom); f.dry1 = 24'($urandom);
        f.dry2 = 24'($urandom); f.dry3 = 24'($urandom);
        f.bus0 = $urandom; f.bus1 = $urandom; f.bus2 = $urandom; f.bus3 = $urandom;
        if ($urandom_range(3) == 0) begin
            f.bus0 = 32'sh7fffff00; f.bus1 = 32'sh80000100;
        end
        return f;
    endfunction

    task automatic load_period(input int samples, input bit wild);
        frame_t f;
        f = rand_frame(REQ_PERIOD, wild);
        f.cmd = ($urandom_range(9) < 6) ? CMD_RUN : 2'($urandom_range(3));
        pending.push_back(f);
        for (int i = 0; i < samples; i++) pending.push_back(rand_frame(REQ_SAMPLE, wild));
    endtask

    task automatic drain_and_write(input logic [22:0] rate, input logic [22:0] depth);
        wait (pending.size() == 0);
        hold_off = 1'b1;
        @(posedge clk);
        while (in_valid || mix_expected.size() != 0) @(posedge clk);
        repeat (250) @(posedge clk);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= REG_RATE; cfg_data <= rate;
        @(posedge clk);
        cfg_index <= REG_DEPTH; cfg_data <= depth;
        @(posedge clk);
        cfg_we <= 1'b0;
        rate_r = rate;
        depth_r = depth;
        hold_off = 1'b0;
    endtask

    initial begin
        frame_t f;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = REG_RATE; cfg_data = '0;
        errors = 0; accepted_items = 0; idle_en = 1'b1; hold_off = 1'b1;
        rate_r = '0; depth_r = '0; mode_r = MODE_OFF;
        cos_r = ONE_V; sin_r = 0; gain_r = 838861; step_r = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        drain_and_write(23'd4194304, 23'd4194304);
        f = '0; f.kind = REQ_PERIOD; f.swell = 24'hffffff; f.cmd = CMD_STOP;
        pending.push_back(f);
        f.kind = REQ_SAMPLE;
        f.dry0 = 24'sh7fffff; f.dry1 = 24'sh800000; f.dry2 = 24'sd0; f.dry3 = -24'sd1;
        f.bus0 = 32'sh7fffffff; f.bus1 = 32'sh80000000; f.bus2 = 32'sd0; f.bus3 = -32'sd1;
        pending.push_back(f);
        f.kind = REQ_PERIOD; f.swell = 24'd0; f.cmd = CMD_RUN;
        pending.push_back(f);
        pending.push_back(rand_frame(REQ_SAMPLE, 1));
        f.cmd = 2'd3; f.swell = 24'd8388608;
        pending.push_back(f);
        f.cmd = CMD_STOP;
        for (int i = 0; i < 4; i++) pending.push_back(f);
        for (int i = 0; i < 12; i++) pending.push_back(rand_frame(REQ_SAMPLE, 1));

        drain_and_write(23'd0, 23'd0);
        load_period(70, 1);
        drain_and_write(23'h7fffff, 23'h7fffff);
        for (int i = 0; i < 6; i++) load_period($urandom_range(1, 6), 1);

        for (int ph = 0; ph < 4; ph++) begin
            drain_and_write(23'($urandom), 23'($urandom_range(4194304)));
            idle_en = (ph != 2);
            for (int i = 0; i < 50; i++) begin
                if ($urandom_range(9) == 0) pending.push_back(rand_frame($urandom_range(1), 1));
                else load_period($urandom_range(1, 12), $urandom_range(4) == 0);
            end
        end
        idle_en = 1'b1;
        drain_and_write(23'd100000, 23'd2000000);

        hold_off = 1'b1;
        wait (pending.size() == 0);
        @(posedge clk);
        while (in_valid || mix_expected.size() != 0) @(posedge clk);
        repeat (250) @(posedge clk);
        if (errors == 0)
            $display("tb_tremolo_gain_ramp_mixer_unit passed");
        else
            $display("tb_tremolo_gain_ramp_mixer_unit failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_tremolo_gain_ramp_mixer_unit failed");
        $finish;
    end
endmodule
